FILE: src/crbw_pkg.sv
// crbw_pkg: shared types and constants for the clipped rectangle blit writer
// no dependencies; used by every other file of the block except crbw_fifo
`default_nettype none

package crbw_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_ROW_PITCH     = 3'd2,
    REG_PIXEL_BYTES   = 3'd3,
    REG_DEST_X        = 3'd4,
    REG_DEST_Y        = 3'd5,
    REG_RECT_WIDTH    = 3'd6,
    REG_RECT_HEIGHT   = 3'd7
  } reg_idx_t;

  // byte lanes of one pixel write, in output order
  typedef enum logic [1:0] {
    LANE_BLUE  = 2'd0,
    LANE_GREEN = 2'd1,
    LANE_RED   = 2'd2,
    LANE_PAD   = 2'd3
  } lane_t;

  // configuration register file contents
  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [15:0] row_pitch;
    logic [2:0]  pixel_bytes;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } cfg_t;

  localparam int          MAX_SCREEN_DIM_DEF = 4096;
  localparam int          QUEUE_DEPTH        = 4;
  localparam int          CFG_DATA_W         = 16;
  localparam int          OFFSET_W           = 28;
  localparam int          RGB_W              = 24;
  localparam logic [2:0]  PIX_BYTES_QUAD     = 3'd4;
  localparam logic [7:0]  PAD_BYTE           = 8'h00;

  // register reset values
  localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd1024;
  localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd768;
  localparam logic [15:0] RST_ROW_PITCH      = 16'd4096;
  localparam logic [2:0]  RST_PIXEL_BYTES    = 3'd4;

endpackage

`default_nettype wire

FILE: src/crbw_if.sv
// crbw_if: valid/ready channel interfaces for pixels, byte writes and config writes
// depends on crbw_pkg
`default_nettype none

interface crbw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;
  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

interface crbw_out_if;
  logic                         valid;
  logic                         ready;
  logic [crbw_pkg::OFFSET_W-1:0] byte_offset;
  logic [7:0]                   byte_value;
  logic                         pixel_last;
  modport source (output valid, output byte_offset, output byte_value, output pixel_last,
                  input ready);
  modport sink   (input valid, input byte_offset, input byte_value, input pixel_last,
                  output ready);
endinterface

interface crbw_cfg_if;
  logic                            valid;
  logic                            ready;
  crbw_pkg::reg_idx_t              reg_index;
  logic [crbw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/crbw_fifo.sv
// crbw_fifo: small register queue between the classifier and the byte writer
// depends on nothing; DEPTH must be a power of two
`default_nettype none

module crbw_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/crbw_front.sv
// crbw_front: takes source pixels, tracks rectangle position, drops clipped pixels
// depends on crbw_pkg; feeds crbw_fifo
`default_nettype none

module crbw_front #(
  parameter int MAX_SCREEN_DIM = crbw_pkg::MAX_SCREEN_DIM_DEF,
  parameter int CW             = 12,
  parameter int DW             = 2 * CW + crbw_pkg::RGB_W + 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire crbw_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  input  wire logic [31:0]    in_pixel,
  output logic                in_ready,
  input  wire logic           q_full,
  output logic                q_push,
  output logic [DW-1:0]       q_data
);

  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic        accept;
  logic        outside_rect;
  logic [16:0] x_pos, y_pos;
  logic [16:0] col_inc, row_inc;
  logic        visible;
  logic        quad;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the pixel against the rectangle and the screen
  always_comb begin
    outside_rect = (col_r >= cfg.rect_width) || (row_r >= cfg.rect_height);
    x_pos        = {1'b0, cfg.dest_x} + {1'b0, col_r};
    y_pos        = {1'b0, cfg.dest_y} + {1'b0, row_r};
    visible      = (x_pos < 17'(cfg.screen_width))  && (x_pos < 17'(MAX_SCREEN_DIM)) &&
                   (y_pos < 17'(cfg.screen_height)) && (y_pos < 17'(MAX_SCREEN_DIM));
    quad         = (cfg.pixel_bytes == crbw_pkg::PIX_BYTES_QUAD);
    q_push       = accept && !outside_rect && visible;
    q_data       = {quad, in_pixel[crbw_pkg::RGB_W-1:0], y_pos[CW-1:0], x_pos[CW-1:0]};
  end

  // column and row advance with wrap at row and rectangle end
  always_comb begin
    col_inc = {1'b0, col_r} + 17'd1;
    row_inc = {1'b0, row_r} + 17'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      priority if (outside_rect) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= {1'b0, cfg.rect_width}) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, cfg.rect_height}) ? '0 : row_inc[15:0];
      end else begin
        col_nxt = col_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/crbw_back.sv
// crbw_back: turns queued pixels into byte writes, one byte per cycle while out_ready holds
// depends on crbw_pkg; fed by crbw_fifo
`default_nettype none

module crbw_back #(
  parameter int CW = 12,
  parameter int DW = 2 * CW + crbw_pkg::RGB_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire crbw_pkg::cfg_t                cfg,
  input  wire logic                          q_not_empty,
  input  wire logic [DW-1:0]                 q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [crbw_pkg::OFFSET_W-1:0]      out_byte_offset,
  output logic [7:0]                         out_byte_value,
  output logic                               out_pixel_last
);

  localparam int OW = crbw_pkg::OFFSET_W;
  localparam int PW = CW + 16;

  // queue entry fields
  logic [CW-1:0]               q_x, q_y;
  logic [crbw_pkg::RGB_W-1:0]  q_rgb;
  logic                        q_quad;
  logic [PW-1:0]               prod_w;
  logic [OW-1:0]               xs_w;

  // address stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [OW-1:0]               prod_r, xs_r;
  logic [crbw_pkg::RGB_W-1:0]  s1_rgb_r;
  logic                        s1_quad_r;

  // byte emitter
  logic                        em_valid_r, em_valid_nxt;
  logic [OW-1:0]               off_r;
  logic [crbw_pkg::RGB_W-1:0]  em_rgb_r;
  logic                        em_quad_r;
  crbw_pkg::lane_t             lane_r, lane_nxt;
  logic                        em_last, em_done, em_load, s1_free;

  assign {q_quad, q_rgb, q_y, q_x} = q_data;

  // row offset product and column offset
  always_comb begin
    prod_w = PW'(q_y) * PW'(cfg.row_pitch);
    xs_w   = q_quad ? OW'({q_x, 2'b00}) : (OW'(q_x) + OW'({q_x, 1'b0}));
  end

  // stage handoff
  always_comb begin
    em_last      = em_quad_r ? (lane_r == crbw_pkg::LANE_PAD) : (lane_r == crbw_pkg::LANE_RED);
    em_done      = em_valid_r && out_ready && em_last;
    em_load      = s1_valid_r && (!em_valid_r || em_done);
    s1_free      = !s1_valid_r || em_load;
    q_pop        = q_not_empty && s1_free;
    s1_valid_nxt = q_pop || (s1_valid_r && !em_load);
    em_valid_nxt = em_load || (em_valid_r && !em_done);
    lane_nxt     = lane_r;
    if (em_load) begin
      lane_nxt = crbw_pkg::LANE_BLUE;
    end else if (em_valid_r && out_ready && !em_last) begin
      lane_nxt = crbw_pkg::lane_t'(lane_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      em_valid_r <= 1'b0;
      lane_r     <= crbw_pkg::LANE_BLUE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      em_valid_r <= em_valid_nxt;
      lane_r     <= lane_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r    <= OW'(prod_w);
      xs_r      <= xs_w;
      s1_rgb_r  <= q_rgb;
      s1_quad_r <= q_quad;
    end
    if (em_load) begin
      off_r     <= prod_r + xs_r;
      em_rgb_r  <= s1_rgb_r;
      em_quad_r <= s1_quad_r;
    end else if (em_valid_r && out_ready) begin
      off_r     <= off_r + OW'(1);
    end
  end

  // byte lane select
  always_comb begin
    unique case (lane_r)
      crbw_pkg::LANE_BLUE:  out_byte_value = em_rgb_r[7:0];
      crbw_pkg::LANE_GREEN: out_byte_value = em_rgb_r[15:8];
      crbw_pkg::LANE_RED:   out_byte_value = em_rgb_r[23:16];
      crbw_pkg::LANE_PAD:   out_byte_value = crbw_pkg::PAD_BYTE;
      default:              out_byte_value = crbw_pkg::PAD_BYTE;
    endcase
  end

  assign out_valid       = em_valid_r;
  assign out_byte_offset = off_r;
  assign out_pixel_last  = em_last;

endmodule

`default_nettype wire

FILE: src/clipped_rect_blit_writer_top.sv
// clipped_rect_blit_writer_top: register file, classifier, queue and byte writer
// depends on crbw_pkg, crbw_if, crbw_fifo, crbw_front, crbw_back
//
//   channel   dir   handshake      carries
//   in_ch     in    valid/ready    src_pixel, one per request
//   out_ch    out   valid/ready    byte_offset, byte_value, pixel_last
//   cfg_ch    in    valid/ready    reg_index, data (always ready)
//
// a visible pixel is written as 4 bytes on out_ch in 4-byte mode, 3 in 3-byte mode;
// the single byte-write port limits throughput; clipped pixels are dropped at the front
// first byte is offered after the pixel passes the queue, address stage and emitter, with the back idle
// reset clears counters, queue and stages and loads the register defaults
// out_ch stalls fill the two back stages and the 4-entry queue, then in_ch.ready drops

`default_nettype none

module clipped_rect_blit_writer_top #(
  parameter int MAX_SCREEN_DIM = crbw_pkg::MAX_SCREEN_DIM_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  crbw_in_if.sink    in_ch,
  crbw_out_if.source out_ch,
  crbw_cfg_if.sink   cfg_ch
);

  localparam int CW = (MAX_SCREEN_DIM > 1) ? $clog2(MAX_SCREEN_DIM) : 1;
  localparam int DW = 2 * CW + crbw_pkg::RGB_W + 1;

  crbw_pkg::cfg_t cfg_r;
  logic           q_push, q_full, q_pop, q_not_empty;
  logic [DW-1:0]  q_wdata, q_rdata;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= crbw_pkg::RST_SCREEN_WIDTH;
      cfg_r.screen_height <= crbw_pkg::RST_SCREEN_HEIGHT;
      cfg_r.row_pitch     <= crbw_pkg::RST_ROW_PITCH;
      cfg_r.pixel_bytes   <= crbw_pkg::RST_PIXEL_BYTES;
      cfg_r.dest_x        <= '0;
      cfg_r.dest_y        <= '0;
      cfg_r.rect_width    <= '0;
      cfg_r.rect_height   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        crbw_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_ch.data[12:0];
        crbw_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_ch.data[12:0];
        crbw_pkg::REG_ROW_PITCH:     cfg_r.row_pitch     <= cfg_ch.data;
        crbw_pkg::REG_PIXEL_BYTES:   cfg_r.pixel_bytes   <= cfg_ch.data[2:0];
        crbw_pkg::REG_DEST_X:        cfg_r.dest_x        <= cfg_ch.data;
        crbw_pkg::REG_DEST_Y:        cfg_r.dest_y        <= cfg_ch.data;
        crbw_pkg::REG_RECT_WIDTH:    cfg_r.rect_width    <= cfg_ch.data;
        crbw_pkg::REG_RECT_HEIGHT:   cfg_r.rect_height   <= cfg_ch.data;
        default:                     cfg_r.rect_height   <= cfg_r.rect_height;
      endcase
    end
  end

  // pixel classifier and position counters
  crbw_front #(
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
    .CW             (CW),
    .DW             (DW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_pixel (in_ch.src_pixel),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // decoupling queue
  crbw_fifo #(
    .DW    (DW),
    .DEPTH (crbw_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_not_empty)
  );

  // byte writer
  crbw_back #(
    .CW (CW),
    .DW (DW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte_offset (out_ch.byte_offset),
    .out_byte_value  (out_ch.byte_value),
    .out_pixel_last  (out_ch.pixel_last)
  );

endmodule

`default_nettype wire

FILE: src/crbw_checker.sv
// crbw_checker: port-level assertions on the byte-write channel
// depends on crbw_pkg; bound to clipped_rect_blit_writer_top
`default_nettype none

module crbw_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [crbw_pkg::OFFSET_W-1:0] out_byte_offset,
  input wire logic                          out_pixel_last
);

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("byte write offered right after reset");

  // a pending request holds until taken
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("byte write request withdrawn");

  // a pixel's bytes follow without a gap
  a_pixel_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_pixel_last |=> out_valid)
    else $error("gap inside a pixel's byte writes");

  // bytes of one pixel go to consecutive offsets
  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_pixel_last |=>
      out_byte_offset == $past(out_byte_offset) + crbw_pkg::OFFSET_W'(1))
    else $error("byte offsets inside a pixel not consecutive");

endmodule

bind clipped_rect_blit_writer_top crbw_checker u_crbw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_byte_offset (out_ch.byte_offset),
  .out_pixel_last  (out_ch.pixel_last)
);

`default_nettype wire
